### src/exact_long_accumulator_macros.svh
// Assertion macros for the exact long accumulator checker.
`ifndef EXACT_LONG_ACCUMULATOR_MACROS_SVH
`define EXACT_LONG_ACCUMULATOR_MACROS_SVH

// same-cycle implication
`define ELA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ELA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/ela_pkg.sv
// Shared constants, codes and control types for the exact long accumulator.
package ela_pkg;

    localparam int FRACTION_WORDS_DEF = 20;
    localparam int EXPONENT_WORDS_DEF = 19;
    localparam int DIGIT_BITS_DEF     = 56;
    localparam int HEADROOM_BITS_DEF  = 8;

    localparam int IDX_W  = 7;
    localparam int POS_W  = 14;
    localparam int IN_DW  = 80;
    localparam int IDXO_W = 6;

    localparam logic [1:0] OP_ADD_DBL = 2'd0;
    localparam logic [1:0] OP_ADD_INT = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    typedef struct packed {
        logic       load;
        logic       div;
        logic       mod;
        logic       shf;
        logic [1:0] piece_sel;
        logic       pick;
        logic       set_ovf;
        logic       rd;
        logic       add_ex;
        logic       norm_init;
        logic       norm_ex;
        logic       out_load;
        logic       out_next;
    } t_cmd;

    typedef struct packed {
        logic is_read;
        logic skip;
        logic piece_nz;
        logic piece_oob;
        logic fits;
        logic idx_last;
        logic out_fire;
    } t_status;

endpackage

### src/ela_controller.sv
// Sequencer for add, normalize and read-out requests.
module ela_controller (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  ela_pkg::t_status i_sts,
    output ela_pkg::t_cmd    o_cmd
);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_DECODE = 12'b000000000010,
        S_MOD    = 12'b000000000100,
        S_SHF    = 12'b000000001000,
        S_PSEL   = 12'b000000010000,
        S_RD     = 12'b000000100000,
        S_EX     = 12'b000001000000,
        S_NRD    = 12'b000010000000,
        S_NEX    = 12'b000100000000,
        S_ORD    = 12'b001000000000,
        S_OLD    = 12'b010000000000,
        S_OWT    = 12'b100000000000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_k, n_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= 2'd0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_k             = r_k;
        o_cmd           = '0;
        o_cmd.piece_sel = r_k;
        o_s_axis_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.is_read) begin
                    o_cmd.norm_init = 1'b1;
                    n_state         = S_NRD;
                end else if (i_sts.skip) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.div = 1'b1;
                    n_state   = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod = 1'b1;
                n_state   = S_SHF;
            end
            S_SHF: begin
                o_cmd.shf = 1'b1;
                n_k       = 2'd0;
                n_state   = S_PSEL;
            end
            S_PSEL: begin
                if (r_k == 2'd3) begin
                    n_state = S_IDLE;
                end else if (!i_sts.piece_nz) begin
                    n_k = r_k + 2'd1;
                end else if (i_sts.piece_oob) begin
                    o_cmd.set_ovf = 1'b1;
                    n_k           = r_k + 2'd1;
                end else begin
                    o_cmd.pick = 1'b1;
                    n_state    = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EX;
            end
            S_EX: begin
                o_cmd.add_ex = 1'b1;
                if (i_sts.fits || i_sts.idx_last) begin
                    n_k     = r_k + 2'd1;
                    n_state = S_PSEL;
                end else begin
                    n_state = S_RD;
                end
            end
            S_NRD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_NEX;
            end
            S_NEX: begin
                o_cmd.norm_ex = 1'b1;
                n_state       = i_sts.idx_last ? S_ORD : S_NRD;
            end
            S_ORD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_OLD;
            end
            S_OLD: begin
                o_cmd.out_load = 1'b1;
                n_state        = S_OWT;
            end
            S_OWT: begin
                if (i_sts.out_fire) begin
                    if (i_sts.idx_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.out_next = 1'b1;
                        n_state        = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### src/ela_datapath.sv
// Word store, alignment, carry-save add, normalization and output register.
module ela_datapath #(
    parameter int FRACTION_WORDS = ela_pkg::FRACTION_WORDS_DEF,
    parameter int EXPONENT_WORDS = ela_pkg::EXPONENT_WORDS_DEF,
    parameter int DIGIT_BITS     = ela_pkg::DIGIT_BITS_DEF,
    parameter int HEADROOM_BITS  = ela_pkg::HEADROOM_BITS_DEF,
    localparam int ODW = ((DIGIT_BITS + ela_pkg::IDXO_W + 7) / 8) * 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [ela_pkg::IN_DW-1:0]  i_s_axis_tdata,
    input  logic [1:0]                 i_s_axis_tuser,
    input  ela_pkg::t_cmd              i_cmd,
    output ela_pkg::t_status           o_sts,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [ODW-1:0]             o_m_axis_tdata,
    output logic [1:0]                 o_m_axis_tuser,
    output logic                       o_m_axis_tlast
);

    localparam int D    = DIGIT_BITS;
    localparam int NW   = FRACTION_WORDS + EXPONENT_WORDS;
    localparam int AW   = $clog2(NW);
    localparam int EH   = (D + HEADROOM_BITS > 64) ? (64 - D) : HEADROOM_BITS;
    localparam int HW   = 66 - D;
    localparam int TW   = D + 2;
    localparam int IW   = ela_pkg::IDX_W;
    localparam int PW   = ela_pkg::POS_W;
    localparam int FD   = FRACTION_WORDS * DIGIT_BITS;
    localparam int RECIP = 65536 / DIGIT_BITS;
    localparam logic signed [HW-1:0] LIM_P   = HW'(2 ** (EH - 1));
    localparam logic signed [HW-1:0] LIM_N   = -LIM_P;
    localparam logic signed [PW-1:0] DBL_OFS = PW'(FD - 1075);
    localparam logic signed [PW-1:0] FIX_OFS = PW'(FD);

    // input decode
    logic [1:0]           in_op;
    logic [63:0]          in_bits;
    logic [10:0]          in_exp;
    logic [63:0]          in_mant;
    logic signed [PW-1:0] pos_d, pos_i, pos_sel;
    logic                 skip_n;

    assign in_op   = i_s_axis_tuser;
    assign in_bits = i_s_axis_tdata[63:0];
    assign in_exp  = in_bits[62:52];
    assign in_mant = {11'd0, 1'b1, in_bits[51:0]};
    assign pos_d   = $signed({{(PW-11){1'b0}}, in_exp}) + DBL_OFS;
    assign pos_i   = $signed({{(PW-12){i_s_axis_tdata[75]}}, i_s_axis_tdata[75:64]}) + FIX_OFS;
    assign pos_sel = (in_op == ela_pkg::OP_ADD_DBL) ? pos_d : pos_i;

    always_comb begin
        case (in_op)
            ela_pkg::OP_ADD_DBL: skip_n = (in_exp == 11'd0) || (in_exp == 11'h7FF) ||
                                          pos_d[PW-1];
            ela_pkg::OP_ADD_INT: skip_n = pos_i[PW-1];
            ela_pkg::OP_READ:    skip_n = 1'b0;
            default:             skip_n = 1'b1;
        endcase
    end

    logic          r_is_read, r_skip;
    logic [63:0]   r_x;
    logic [11:0]   r_pos;
    logic [IW-1:0] r_qest, r_base;
    logic [5:0]    r_s;
    logic [D-1:0]  r_pc0, r_pc1;
    logic [63:0]   r_pc2;
    logic [63:0]   r_v;
    logic [IW-1:0] r_idx;
    logic signed [HW-1:0] r_carry;
    logic          r_ovf, r_neg;

    // alignment
    logic [12:0]   rem_full;
    logic [6:0]    sh1, sh2;
    assign rem_full = 13'(r_pos) - 13'(r_qest * D);
    assign sh1      = 7'(D) - 7'(r_s);
    assign sh2      = 7'(2 * D) - 7'(r_s);

    logic [63:0]   sel_pc;
    logic [IW-1:0] pidx;
    always_comb begin
        case (i_cmd.piece_sel)
            2'd0:    sel_pc = 64'(r_pc0);
            2'd1:    sel_pc = 64'(r_pc1);
            default: sel_pc = r_pc2;
        endcase
    end
    assign pidx = r_base + IW'(i_cmd.piece_sel);

    // store
    logic [63:0]   mem [NW];
    logic [NW-1:0] r_vld;
    logic [63:0]   r_rdata;
    logic          r_rvld;
    logic [63:0]   word;
    logic          we;
    logic [63:0]   wdata;
    logic [AW-1:0] addr;

    assign addr = r_idx[AW-1:0];
    assign word = r_rvld ? r_rdata : 64'd0;

    // carry-save add
    logic signed [63-D:0] whi, vhi;
    logic [D:0]           lo;
    logic signed [HW-1:0] hi;
    logic                 fits;
    assign whi  = $signed(word[63:D]);
    assign vhi  = $signed(r_v[63:D]);
    assign lo   = {1'b0, word[D-1:0]} + {1'b0, r_v[D-1:0]};
    assign hi   = HW'(whi) + HW'(vhi) + $signed({{(HW-1){1'b0}}, lo[D]});
    assign fits = (hi >= LIM_N) && (hi < LIM_P);

    // normalize
    logic signed [TW-1:0] t;
    logic signed [HW-1:0] carry_n;
    logic                 idx_last;
    assign t        = $signed({2'b00, word[D-1:0]}) + TW'(r_carry);
    assign carry_n  = HW'(whi) + HW'($signed(t[TW-1:D]));
    assign idx_last = (r_idx == IW'(NW - 1));

    always_comb begin
        we    = i_cmd.add_ex || i_cmd.norm_ex;
        wdata = '0;
        if (i_cmd.add_ex) begin
            wdata = fits ? {hi[63-D:0], lo[D-1:0]} : {{(64-D){1'b0}}, lo[D-1:0]};
        end else begin
            wdata = {{(64-D){idx_last && carry_n[HW-1]}}, t[D-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (we) begin
                r_vld[addr] <= 1'b1;
            end
            if (i_cmd.rd) begin
                r_rvld <= r_vld[addr];
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_read <= (in_op == ela_pkg::OP_READ);
            r_skip    <= skip_n;
            r_x       <= (in_op == ela_pkg::OP_ADD_DBL && in_bits[63]) ? (64'd0 - in_mant) :
                         (in_op == ela_pkg::OP_ADD_DBL) ? in_mant : in_bits;
            r_pos     <= pos_sel[11:0];
        end
        if (i_cmd.div) begin
            r_qest <= IW'((32'(r_pos) * 32'(RECIP)) >> 16);
        end
        if (i_cmd.mod) begin
            if (rem_full >= 13'(D)) begin
                r_base <= r_qest + IW'(1);
                r_s    <= 6'(rem_full - 13'(D));
            end else begin
                r_base <= r_qest;
                r_s    <= rem_full[5:0];
            end
        end
        if (i_cmd.shf) begin
            r_pc0 <= D'(r_x << r_s);
            r_pc1 <= D'($signed(r_x) >>> sh1);
            r_pc2 <= $signed(r_x) >>> sh2;
        end
        if (i_cmd.pick) begin
            r_v   <= sel_pc;
            r_idx <= pidx;
        end
        if (i_cmd.add_ex && !fits) begin
            r_v   <= 64'(hi);
            r_idx <= r_idx + IW'(1);
        end
        if (i_cmd.norm_init) begin
            r_idx   <= '0;
            r_carry <= '0;
        end
        if (i_cmd.norm_ex) begin
            r_carry <= carry_n;
            r_idx   <= idx_last ? '0 : r_idx + IW'(1);
        end
        if (i_cmd.out_next) begin
            r_idx <= r_idx + IW'(1);
        end
        if (i_cmd.out_load) begin
            o_m_axis_tdata <= ODW'({r_idx[ela_pkg::IDXO_W-1:0], word[D-1:0]});
            o_m_axis_tlast <= idx_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf           <= 1'b0;
            r_neg           <= 1'b0;
            o_m_axis_tvalid <= 1'b0;
        end else begin
            if (i_cmd.set_ovf || (i_cmd.add_ex && !fits && idx_last)) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.norm_ex && idx_last) begin
                if (carry_n != '0 && carry_n != '1) begin
                    r_ovf <= 1'b1;
                end
                r_neg <= carry_n[HW-1];
            end
            if (i_cmd.out_load) begin
                o_m_axis_tvalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                o_m_axis_tvalid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tuser = {r_ovf, r_neg};

    assign o_sts.is_read   = r_is_read;
    assign o_sts.skip      = r_skip;
    assign o_sts.piece_nz  = (sel_pc != 64'd0);
    assign o_sts.piece_oob = (pidx >= IW'(NW));
    assign o_sts.fits      = fits;
    assign o_sts.idx_last  = idx_last;
    assign o_sts.out_fire  = o_m_axis_tvalid && i_m_axis_tready;

endmodule

### src/exact_long_accumulator.sv
// Add: decode, divide, remainder and shift, then for each nonzero piece a read and add
// per word touched, with the carry rippling up through further words of the store.
// Read-out: normalize every word, then read, load and send each digit to the sink.
// One request at a time; the input is ready only while idle.
// Synchronous active-low reset clears the store, sticky overflow flag and control.
module exact_long_accumulator #(
    parameter int FRACTION_WORDS = ela_pkg::FRACTION_WORDS_DEF,
    parameter int EXPONENT_WORDS = ela_pkg::EXPONENT_WORDS_DEF,
    parameter int DIGIT_BITS     = ela_pkg::DIGIT_BITS_DEF,
    parameter int HEADROOM_BITS  = ela_pkg::HEADROOM_BITS_DEF,
    localparam int ODW = ((DIGIT_BITS + ela_pkg::IDXO_W + 7) / 8) * 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [ela_pkg::IN_DW-1:0] i_s_axis_tdata,  // operand_bits, scale_exponent
    input  logic [1:0]                i_s_axis_tuser,  // operation
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [ODW-1:0]            o_m_axis_tdata,  // digit_word, word_index
    output logic [1:0]                o_m_axis_tuser,  // sum_negative, overflowed
    output logic                      o_m_axis_tlast
);

    ela_pkg::t_cmd    cmd;
    ela_pkg::t_status sts;

    ela_controller u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_sts           (sts),
        .o_cmd           (cmd)
    );

    ela_datapath #(
        .FRACTION_WORDS (FRACTION_WORDS),
        .EXPONENT_WORDS (EXPONENT_WORDS),
        .DIGIT_BITS     (DIGIT_BITS),
        .HEADROOM_BITS  (HEADROOM_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

### src/ela_checker.sv
// Port-level checker for the exact long accumulator, bound to the top level.
`include "exact_long_accumulator_macros.svh"

module ela_checker #(
    parameter int FRACTION_WORDS = ela_pkg::FRACTION_WORDS_DEF,
    parameter int EXPONENT_WORDS = ela_pkg::EXPONENT_WORDS_DEF,
    parameter int DIGIT_BITS     = ela_pkg::DIGIT_BITS_DEF,
    localparam int ODW = ((DIGIT_BITS + ela_pkg::IDXO_W + 7) / 8) * 8
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_s_axis_tvalid,
    input logic                      o_s_axis_tready,
    input logic [ela_pkg::IN_DW-1:0] i_s_axis_tdata,
    input logic [1:0]                i_s_axis_tuser,
    input logic                      o_m_axis_tvalid,
    input logic                      i_m_axis_tready,
    input logic [ODW-1:0]            o_m_axis_tdata,
    input logic [1:0]                o_m_axis_tuser,
    input logic                      o_m_axis_tlast
);

    localparam int NW = FRACTION_WORDS + EXPONENT_WORDS;

    logic out_req, in_read;
    assign out_req = o_m_axis_tvalid && i_m_axis_tready;
    assign in_read = i_s_axis_tvalid && o_s_axis_tready &&
                     (i_s_axis_tuser == ela_pkg::OP_READ);

    `ELA_ASSERT_IMP(a_no_input_during_readout, o_m_axis_tvalid, !o_s_axis_tready, "input ready during read-out")
    `ELA_ASSERT_IMP(a_last_is_top_word, o_m_axis_tvalid && o_m_axis_tlast, o_m_axis_tdata[DIGIT_BITS +: ela_pkg::IDXO_W] == ela_pkg::IDXO_W'(NW - 1), "last digit not at top index")
    `ELA_ASSERT_NXT(a_run_flags_hold, out_req && !o_m_axis_tlast, !o_s_axis_tready && $stable(o_m_axis_tuser), "read-out run broken or flags changed")
    `ELA_ASSERT_NXT(a_read_busy, in_read, !o_s_axis_tready, "read request did not start a read-out")

endmodule

bind exact_long_accumulator ela_checker #(
    .FRACTION_WORDS (FRACTION_WORDS),
    .EXPONENT_WORDS (EXPONENT_WORDS),
    .DIGIT_BITS     (DIGIT_BITS)
) u_ela_checker (.*);
